### rtl/ymtf_pkg.sv
// Package for the yaw moment block: widths, CORDIC constants, register map.
// No dependencies.
`default_nettype none
package ymtf_pkg;
    localparam int FORCE_BITS = 16;
    localparam int TRIG_ITERATIONS = 16;
    localparam int ANG_BITS = 16;
    localparam int DIST_BITS = 16;
    localparam int MOM_BITS = 24;
    localparam int TRIG_BITS = 16;          // Q1.14 cos/sin, range +-16384
    localparam int CW = 34;                 // CORDIC x/y/z width
    localparam int ROT_BITS = FORCE_BITS + 6; // rotated force, 0.25N*2^-2
    localparam int PROD_BITS = ROT_BITS + DIST_BITS + 3;
    localparam int SUM_BITS = PROD_BITS + 3;
    localparam logic signed [ANG_BITS-1:0] ANG_HALF_PI = 16'sd12868;
    localparam logic signed [ANG_BITS-1:0] ANG_PI = 16'sd25736;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032875;
    localparam logic signed [TRIG_BITS-1:0] ONE_Q14 = 16'sd16384;
    localparam int ADDR_BITS = 4;
    localparam logic [ADDR_BITS-1:0] REG_FRONT = 4'd0;
    localparam logic [ADDR_BITS-1:0] REG_REAR = 4'd4;
    localparam logic [ADDR_BITS-1:0] REG_TRACK = 4'd8;

    typedef logic signed [FORCE_BITS-1:0] t_force;

    typedef struct packed {
        logic [DIST_BITS-1:0] front;
        logic [DIST_BITS-1:0] rear;
        logic [DIST_BITS-1:0] track;
    } t_geom;

    function automatic logic signed [CW-1:0] arc(input int i);
        logic signed [CW-1:0] r;
        case (i)
            0: r = 34'sd210828714;
            1: r = 34'sd124459457;
            2: r = 34'sd65760959;
            3: r = 34'sd33381290;
            4: r = 34'sd16755422;
            5: r = 34'sd8385879;
            6: r = 34'sd4193963;
            7: r = 34'sd2097109;
            8: r = 34'sd1048571;
            9: r = 34'sd524287;
            default: r = 34'sd262144 >>> (i - 10);
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

### rtl/ymtf_cordic_stage.sv
// One rotation step of the sine/cosine CORDIC, registered.
// Depends on ymtf_pkg.
`default_nettype none
module ymtf_cordic_stage (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [4:0]                    i_step,
    input  wire logic signed [ymtf_pkg::CW-1:0] i_x,
    input  wire logic signed [ymtf_pkg::CW-1:0] i_y,
    input  wire logic signed [ymtf_pkg::CW-1:0] i_z,
    output logic signed [ymtf_pkg::CW-1:0]      o_x,
    output logic signed [ymtf_pkg::CW-1:0]      o_y,
    output logic signed [ymtf_pkg::CW-1:0]      o_z
);
    logic signed [ymtf_pkg::CW-1:0] dx, dy, at;
    assign dx = i_y >>> i_step;
    assign dy = i_x >>> i_step;
    assign at = ymtf_pkg::arc(int'(i_step));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_z[ymtf_pkg::CW-1]) begin
                o_x <= i_x - dx; o_y <= i_y + dy; o_z <= i_z - at;
            end else begin
                o_x <= i_x + dx; o_y <= i_y - dy; o_z <= i_z + at;
            end
        end
    end
endmodule
`default_nettype wire

### rtl/ymtf_lane.sv
// One wheel lane: rotates the wheel forces (rear lanes use cos 1, sin 0)
// and forms dist*Fy and track*Fx terms, two register stages. Uses ymtf_pkg.
`default_nettype none
module ymtf_lane (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_en,
    input  wire logic                                 i_front,
    input  wire logic signed [ymtf_pkg::TRIG_BITS-1:0] i_cos,
    input  wire logic signed [ymtf_pkg::TRIG_BITS-1:0] i_sin,
    input  wire ymtf_pkg::t_force                      i_fx,
    input  wire ymtf_pkg::t_force                      i_fy,
    input  wire logic [ymtf_pkg::DIST_BITS-1:0]        i_dist,
    input  wire logic [ymtf_pkg::DIST_BITS-1:0]        i_track,
    output logic signed [ymtf_pkg::PROD_BITS-1:0]      o_lat_term,
    output logic signed [ymtf_pkg::PROD_BITS-1:0]      o_long_term
);
    localparam int PW = ymtf_pkg::FORCE_BITS + ymtf_pkg::TRIG_BITS + 1;
    logic signed [PW-1:0] r_cx, r_sy, r_sx, r_cy, pxs, pys;
    logic signed [ymtf_pkg::ROT_BITS-1:0] rx, ry;
    logic [ymtf_pkg::DIST_BITS-1:0] r_dist, r_track;
    logic signed [ymtf_pkg::FORCE_BITS-1:0] r_fx, r_fy;
    logic r_front;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx <= PW'(i_cos * i_fx);
            r_sy <= PW'(i_sin * i_fy);
            r_sx <= PW'(i_sin * i_fx);
            r_cy <= PW'(i_cos * i_fy);
            r_fx <= i_fx; r_fy <= i_fy; r_front <= i_front;
            r_dist <= i_dist; r_track <= i_track;
        end
    end

    // round half up from 2^-14 to 2^-2 scale
    assign pxs = r_cx - r_sy + PW'(2048);
    assign pys = r_sx + r_cy + PW'(2048);
    always_comb begin
        if (r_front) begin
            rx = ymtf_pkg::ROT_BITS'(pxs >>> 12);
            ry = ymtf_pkg::ROT_BITS'(pys >>> 12);
        end else begin
            rx = ymtf_pkg::ROT_BITS'(r_fx) <<< 2;
            ry = ymtf_pkg::ROT_BITS'(r_fy) <<< 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_lat_term <= ymtf_pkg::PROD_BITS'(ry * $signed({2'b0, r_dist})) <<< 1;
            o_long_term <= ymtf_pkg::PROD_BITS'(rx * $signed({1'b0, r_track}));
        end
    end
endmodule
`default_nettype wire

### rtl/yaw_moment_from_tire_forces.sv
// Top level of the yaw moment block: APB registers, CORDIC pipeline,
// four wheel lanes and the merging sum. Uses ymtf_pkg, ymtf_cordic_stage, ymtf_lane.
//
// channel  | handshake                   | payload
// input    | i_valid / o_stall           | 8 forces, steer angle
// output   | o_valid / i_stall           | yaw moment, saturated flag
// config   | psel penable pwrite pready  | paddr, pwdata, prdata
//
// TRIG_ITERATIONS+6 register stages, among them the CORDIC pipeline of one
// stage per iteration; one request per cycle while not stalled. The pipeline
// advances as one unit whenever the output register is empty or being
// taken; a stall holds every stage. Reset clears valid bits and restores
// register defaults.
`default_nettype none
module yaw_moment_from_tire_forces (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire ymtf_pkg::t_force i_front_left_long_force,
    input  wire ymtf_pkg::t_force i_front_right_long_force,
    input  wire ymtf_pkg::t_force i_rear_left_long_force,
    input  wire ymtf_pkg::t_force i_rear_right_long_force,
    input  wire ymtf_pkg::t_force i_front_left_lat_force,
    input  wire ymtf_pkg::t_force i_front_right_lat_force,
    input  wire ymtf_pkg::t_force i_rear_left_lat_force,
    input  wire ymtf_pkg::t_force i_rear_right_lat_force,
    input  wire logic signed [ymtf_pkg::ANG_BITS-1:0] i_steer_angle,
    output logic      o_valid,
    input  wire logic i_stall,
    output logic signed [ymtf_pkg::MOM_BITS-1:0] o_yaw_moment,
    output logic      o_moment_saturated,
    input  wire logic psel,
    input  wire logic penable,
    input  wire logic pwrite,
    input  wire logic [ymtf_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    localparam int N = ymtf_pkg::TRIG_ITERATIONS;
    localparam int CW = ymtf_pkg::CW;
    localparam int DEPTH = N + 6;

    ymtf_pkg::t_geom r_geom;
    logic adv;
    logic [DEPTH-1:0] r_vld;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.front <= 16'd3277; r_geom.rear <= 16'd3277; r_geom.track <= 16'd4915;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                ymtf_pkg::REG_FRONT: r_geom.front <= pwdata[15:0];
                ymtf_pkg::REG_REAR:  r_geom.rear <= pwdata[15:0];
                ymtf_pkg::REG_TRACK: r_geom.track <= pwdata[15:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (paddr)
            ymtf_pkg::REG_FRONT: prdata = {16'd0, r_geom.front};
            ymtf_pkg::REG_REAR:  prdata = {16'd0, r_geom.rear};
            ymtf_pkg::REG_TRACK: prdata = {16'd0, r_geom.track};
            default: prdata = '0;
        endcase
    end

    assign adv = !o_valid || !i_stall;
    assign o_stall = !adv;
    assign o_valid = r_vld[DEPTH-1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (adv) r_vld <= {r_vld[DEPTH-2:0], i_valid};
    end

    // angle fold beyond a right angle
    logic signed [15:0] ang;
    logic neg_in;
    always_comb begin
        neg_in = 1'b0;
        ang = i_steer_angle;
        if (i_steer_angle > ymtf_pkg::ANG_HALF_PI) begin
            ang = ymtf_pkg::ANG_PI - i_steer_angle; neg_in = 1'b1;
        end else if (i_steer_angle < -ymtf_pkg::ANG_HALF_PI) begin
            ang = -ymtf_pkg::ANG_PI - i_steer_angle; neg_in = 1'b1;
        end
    end

    logic signed [CW-1:0] cx [N+1], cy [N+1], cz [N+1];
    logic [N:0] r_neg;
    ymtf_pkg::t_force r_fx [N+1][4];
    ymtf_pkg::t_force r_fy [N+1][4];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            cx[0] <= ymtf_pkg::CORDIC_GAIN;
            cy[0] <= '0;
            cz[0] <= CW'(ang) <<< 15;
            r_neg[0] <= neg_in;
            r_fx[0][0] <= i_front_left_long_force;  r_fy[0][0] <= i_front_left_lat_force;
            r_fx[0][1] <= i_front_right_long_force; r_fy[0][1] <= i_front_right_lat_force;
            r_fx[0][2] <= i_rear_left_long_force;   r_fy[0][2] <= i_rear_left_lat_force;
            r_fx[0][3] <= i_rear_right_long_force;  r_fy[0][3] <= i_rear_right_lat_force;
            for (int k = 0; k < N; k++) begin
                r_neg[k+1] <= r_neg[k];
                r_fx[k+1] <= r_fx[k];
                r_fy[k+1] <= r_fy[k];
            end
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_cordic
        ymtf_cordic_stage u_stage (
            .i_clk(i_clk), .i_en(adv), .i_step(5'(g)),
            .i_x(cx[g]), .i_y(cy[g]), .i_z(cz[g]),
            .o_x(cx[g+1]), .o_y(cy[g+1]), .o_z(cz[g+1])
        );
    end

    // round to Q1.14 and clamp
    logic signed [CW-1:0] xr, yr;
    logic signed [ymtf_pkg::TRIG_BITS-1:0] r_cos, r_sin;
    ymtf_pkg::t_force r_fx2 [4];
    ymtf_pkg::t_force r_fy2 [4];
    assign xr = (cx[N] + CW'(32768)) >>> 16;
    assign yr = (cy[N] + CW'(32768)) >>> 16;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            logic signed [ymtf_pkg::TRIG_BITS-1:0] t;
            if (xr > CW'(ymtf_pkg::ONE_Q14)) t = ymtf_pkg::ONE_Q14;
            else if (xr < -CW'(ymtf_pkg::ONE_Q14)) t = -ymtf_pkg::ONE_Q14;
            else t = ymtf_pkg::TRIG_BITS'(xr);
            r_cos <= r_neg[N] ? -t : t;
            if (yr > CW'(ymtf_pkg::ONE_Q14)) r_sin <= ymtf_pkg::ONE_Q14;
            else if (yr < -CW'(ymtf_pkg::ONE_Q14)) r_sin <= -ymtf_pkg::ONE_Q14;
            else r_sin <= ymtf_pkg::TRIG_BITS'(yr);
            r_fx2 <= r_fx[N];
            r_fy2 <= r_fy[N];
        end
    end

    logic signed [ymtf_pkg::PROD_BITS-1:0] lat_t [4], long_t [4];
    for (genvar w = 0; w < 4; w++) begin : g_lane
        ymtf_lane u_lane (
            .i_clk(i_clk), .i_en(adv), .i_front(w < 2),
            .i_cos(w < 2 ? r_cos : ymtf_pkg::ONE_Q14),
            .i_sin(w < 2 ? r_sin : '0),
            .i_fx(r_fx2[w]), .i_fy(r_fy2[w]),
            .i_dist(w < 2 ? r_geom.front : r_geom.rear),
            .i_track(r_geom.track),
            .o_lat_term(lat_t[w]), .o_long_term(long_t[w])
        );
    end

    // merge: left wheels subtract track term, rear wheels subtract lat term
    localparam int SB = ymtf_pkg::SUM_BITS;
    logic signed [SB-1:0] r_s0, r_s1, sum, m;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0 <= SB'(lat_t[0]) - SB'(long_t[0]) + SB'(lat_t[1]) + SB'(long_t[1]);
            r_s1 <= -SB'(lat_t[2]) - SB'(long_t[2]) - SB'(lat_t[3]) + SB'(long_t[3]);
        end
    end
    assign sum = r_s0 + r_s1 + SB'(16384);
    assign m = sum >>> 15;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (m > SB'(8388607)) begin
                o_yaw_moment <= 24'sh7FFFFF; o_moment_saturated <= 1'b1;
            end else if (m < -SB'(8388608)) begin
                o_yaw_moment <= 24'sh800000; o_moment_saturated <= 1'b1;
            end else begin
                o_yaw_moment <= 24'(m); o_moment_saturated <= 1'b0;
            end
        end
    end

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_yaw_moment))
        else $error("result lost under stall");
    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_moment_saturated |->
            (o_yaw_moment == 24'sh7FFFFF || o_yaw_moment == 24'sh800000))
        else $error("saturation flag without clipped value");
    a_stall_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while pipeline could move");
endmodule
`default_nettype wire
